/* rtl/bctl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctl_pkg
// Shared types and constants for the block cache tag and replacement engine.
// ----------------------------------------------------------------------------
package bctl_pkg;

  // Request operation codes.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_INVAL = 2'd2;

  localparam int unsigned OP_BITS        = 2;
  localparam int unsigned TAG_BITS       = 32;
  localparam int unsigned AGE_BITS       = 64;
  localparam int unsigned ENTRY_IDX_BITS = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

/* rtl/bctl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bctl_ram #(
  parameter int unsigned WIDTH = 100,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

/* rtl/block_cache_tag_lru.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_cache_tag_lru
// Tag lookup and least-recently-used replacement for a fully associative
// disk block cache.
//
// A request is accepted in the idle state and scanned, its result is then
// registered in the update state, and the next request is accepted once the
// sequencer is back in the idle state. A result still held by out_stall
// delays the update state until the output register frees. The scan is a
// single pass over the entry RAM, one entry per cycle through its one read
// port, doing the tag match, the first-free search and the smallest-age
// search together (an invalidate instead clears the owner's valid entries);
// an unused op code skips the scan. A result waits in the output register
// while the next request is accepted and scanned. Valid bits are flops
// cleared by reset; owner, tag and age live in the RAM and are only read
// under a set valid bit, but for the age of entry zero, which seeds the age
// search and is used only when no entry is free, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module block_cache_tag_lru #(
  parameter int unsigned ENTRIES    = 32,
  parameter int unsigned FS_ID_BITS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bctl_pkg::OP_BITS-1:0]         in_op,
  input  logic [FS_ID_BITS-1:0]                in_fs_id,
  input  logic [bctl_pkg::TAG_BITS-1:0]        in_block_number,
  input  logic                                 in_device_ok,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_ok,
  output logic                                 out_hit,
  output logic [bctl_pkg::ENTRY_IDX_BITS-1:0]  out_entry_index
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned TAG_W  = bctl_pkg::TAG_BITS;
  localparam int unsigned AGE_W  = bctl_pkg::AGE_BITS;
  localparam int unsigned WORD_W = FS_ID_BITS + TAG_W + AGE_W;

  bctl_pkg::state_t state_r, state_nxt;

  // Request registers.
  logic [bctl_pkg::OP_BITS-1:0] op_r, op_nxt;
  logic [FS_ID_BITS-1:0]        fs_r, fs_nxt;
  logic [TAG_W-1:0]             tag_r, tag_nxt;
  logic                         dev_ok_r, dev_ok_nxt;

  // Scan control.
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cmp_en_r, cmp_en_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;

  // Scan results.
  logic             hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             inv_found_r, inv_found_nxt;
  logic [IDX_W-1:0] inv_idx_r, inv_idx_nxt;
  logic [AGE_W-1:0] min_age_r, min_age_nxt;
  logic [IDX_W-1:0] min_idx_r, min_idx_nxt;

  logic [AGE_W-1:0] clock_r, clock_nxt;
  logic             valid_r [ENTRIES];
  logic             valid_nxt [ENTRIES];

  logic                                out_valid_r, out_valid_nxt;
  logic                                out_ok_r, out_ok_nxt;
  logic                                out_hit_r, out_hit_nxt;
  logic [bctl_pkg::ENTRY_IDX_BITS-1:0] out_idx_r, out_idx_nxt;

  // Sequencer outputs.
  logic             in_accept;
  logic             scan_issue;
  logic             upd_go;

  // RAM port.
  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic [IDX_W-1:0]  ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;

  logic [FS_ID_BITS-1:0] e_owner;
  logic [TAG_W-1:0]      e_tag;
  logic [AGE_W-1:0]      e_age;
  logic                  e_valid;

  // Result of the current request, valid in the update state.
  logic             res_ok;
  logic             res_hit;
  logic             res_stamp;
  logic [IDX_W-1:0] res_idx;

  bctl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (scan_issue),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign e_owner = ram_rd_data[WORD_W-1 -: FS_ID_BITS];
  assign e_tag   = ram_rd_data[AGE_W +: TAG_W];
  assign e_age   = ram_rd_data[AGE_W-1:0];
  assign e_valid = valid_r[cmp_idx_r];

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bctl_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_op inside {bctl_pkg::OP_READ, bctl_pkg::OP_WRITE,
                            bctl_pkg::OP_INVAL}) begin
            state_nxt = bctl_pkg::ST_SCAN;
          end else begin
            state_nxt = bctl_pkg::ST_UPDATE;
          end
        end
      end
      bctl_pkg::ST_SCAN: begin
        if (cnt_r == CNT_W'(ENTRIES)) begin
          state_nxt = bctl_pkg::ST_UPDATE;
        end
      end
      bctl_pkg::ST_UPDATE: begin
        if (upd_go) begin
          state_nxt = bctl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bctl_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall    = 1'b1;
    scan_issue  = 1'b0;
    upd_go      = 1'b0;
    ram_rd_addr = cnt_r[IDX_W-1:0];
    case (state_r)
      bctl_pkg::ST_IDLE:   in_stall = 1'b0;
      bctl_pkg::ST_SCAN:   scan_issue = (cnt_r != CNT_W'(ENTRIES));
      bctl_pkg::ST_UPDATE: upd_go = !out_valid_r || !out_stall;
      default:             in_stall = 1'b1;
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  // Result selection for read, write and invalidate requests.
  always_comb begin
    res_ok    = 1'b0;
    res_hit   = 1'b0;
    res_stamp = 1'b0;
    res_idx   = '0;
    case (op_r)
      bctl_pkg::OP_INVAL: res_ok = 1'b1;
      bctl_pkg::OP_READ, bctl_pkg::OP_WRITE: begin
        // A read hit needs no device access; a write always does.
        if (hit_found_r && (op_r == bctl_pkg::OP_READ || dev_ok_r)) begin
          res_ok    = 1'b1;
          res_hit   = 1'b1;
          res_stamp = 1'b1;
          res_idx   = hit_idx_r;
        end else if (!hit_found_r && dev_ok_r) begin
          res_ok    = 1'b1;
          res_stamp = 1'b1;
          res_idx   = inv_found_r ? inv_idx_r : min_idx_r;
        end
      end
      default: res_ok = 1'b0;
    endcase
  end

  assign ram_wr_en   = upd_go && res_stamp;
  assign ram_wr_addr = res_idx;
  assign ram_wr_data = {fs_r, tag_r, clock_nxt};

  // Datapath next values.
  always_comb begin
    op_nxt        = op_r;
    fs_nxt        = fs_r;
    tag_nxt       = tag_r;
    dev_ok_nxt    = dev_ok_r;
    cnt_nxt       = cnt_r;
    cmp_en_nxt    = scan_issue;
    cmp_idx_nxt   = ram_rd_addr;
    hit_found_nxt = hit_found_r;
    hit_idx_nxt   = hit_idx_r;
    inv_found_nxt = inv_found_r;
    inv_idx_nxt   = inv_idx_r;
    min_age_nxt   = min_age_r;
    min_idx_nxt   = min_idx_r;
    clock_nxt     = clock_r + AGE_W'(1);
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_hit_nxt   = out_hit_r;
    out_idx_nxt   = out_idx_r;

    if (in_accept) begin
      op_nxt        = in_op;
      fs_nxt        = in_fs_id;
      tag_nxt       = in_block_number;
      dev_ok_nxt    = in_device_ok;
      cnt_nxt       = '0;
      hit_found_nxt = 1'b0;
      inv_found_nxt = 1'b0;
    end

    if (scan_issue) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (cmp_en_r) begin
      if (op_r == bctl_pkg::OP_INVAL) begin
        if (e_valid && e_owner == fs_r) begin
          valid_nxt[cmp_idx_r] = 1'b0;
        end
      end else begin
        if (e_valid && e_owner == fs_r && e_tag == tag_r && !hit_found_r) begin
          hit_found_nxt = 1'b1;
          hit_idx_nxt   = cmp_idx_r;
        end
        if (!e_valid && !inv_found_r) begin
          inv_found_nxt = 1'b1;
          inv_idx_nxt   = cmp_idx_r;
        end
        // Entry zero seeds the age search; a strict compare keeps the
        // lowest index on a tie.
        if (cmp_idx_r == '0) begin
          min_age_nxt = e_age;
          min_idx_nxt = '0;
        end else if (e_valid && e_age < min_age_r) begin
          min_age_nxt = e_age;
          min_idx_nxt = cmp_idx_r;
        end
      end
    end

    if (!(upd_go && res_stamp)) begin
      clock_nxt = clock_r;
    end

    if (upd_go) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = res_ok;
      out_hit_nxt   = res_hit;
      out_idx_nxt   = bctl_pkg::ENTRY_IDX_BITS'(res_idx);
      if (res_stamp) begin
        valid_nxt[res_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bctl_pkg::ST_IDLE;
      cmp_en_r    <= 1'b0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      cmp_en_r    <= cmp_en_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    fs_r        <= fs_nxt;
    tag_r       <= tag_nxt;
    dev_ok_r    <= dev_ok_nxt;
    cnt_r       <= cnt_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    hit_found_r <= hit_found_nxt;
    hit_idx_r   <= hit_idx_nxt;
    inv_found_r <= inv_found_nxt;
    inv_idx_r   <= inv_idx_nxt;
    min_age_r   <= min_age_nxt;
    min_idx_r   <= min_idx_nxt;
    out_ok_r    <= out_ok_nxt;
    out_hit_r   <= out_hit_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_hit         = out_hit_r;
  assign out_entry_index = out_idx_r;

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("request accepted while another is in flight");

  // A new result is only ever produced at the end of the update state.
  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bctl_pkg::ST_UPDATE))
    else $error("result produced outside the update state");

  // The access clock only ever steps by one, and only with a stamping update.
  a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(clock_r)) |->
      (clock_r == $past(clock_r) + AGE_W'(1) && $past(ram_wr_en)))
    else $error("access clock changed without a stamping update");

  // A stamped entry is valid afterwards.
  a_stamp_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |=> valid_r[$past(ram_wr_addr)])
    else $error("stamped entry not marked valid");

endmodule
